@@ src/tspmt_pkg.sv @@
// ----------------------------------------------------------------------------
// tspmt_pkg - shared types and constants for the TS PMT rewriter
// Stream constants, register map, CRC-32/MPEG-2 byte update and the
// config / status bundles passed between modules.
// ----------------------------------------------------------------------------
package tspmt_pkg;

  localparam logic [7:0]  SYNC_BYTE = 8'h47;
  localparam logic [7:0]  AC3_TYPE  = 8'h81;
  localparam logic [31:0] CRC_POLY  = 32'h04c1_1db7;
  localparam logic [31:0] CRC_INIT  = 32'hffff_ffff;
  localparam logic [7:0]  PKT_LEN   = 8'd188;
  localparam logic [7:0]  PKT_LAST  = 8'(PKT_LEN - 8'd1);

  localparam int MAX_STREAMS_DEF = 16;

  // APB register map, one word per register
  localparam int ADDR_W = 5;
  localparam logic [2:0] REG_PMT_ENABLE   = 3'd0;
  localparam logic [2:0] REG_PMT_PID      = 3'd1;
  localparam logic [2:0] REG_AC3_ENABLE   = 3'd2;
  localparam logic [2:0] REG_AC3_PID      = 3'd3;
  localparam logic [2:0] REG_STREAM_LIMIT = 3'd4;

  typedef struct packed {
    logic        pmt_enable;
    logic [12:0] pmt_pid;
    logic        ac3_enable;
    logic [12:0] ac3_pid;
    logic [4:0]  stream_limit;
  } cfg_t;

  typedef struct packed {
    logic       in_packet;
    logic [7:0] byte_position;
  } status_t;

  // MSB-first CRC-32/MPEG-2, one byte
  function automatic logic [31:0] crc_feed(input logic [31:0] crc, input logic [7:0] v);
    logic [31:0] c;
    c = crc ^ {v, 24'h0};
    for (int k = 0; k < 8; k++) begin
      c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

@@ src/tspmt_if.sv @@
// ----------------------------------------------------------------------------
// tspmt_if - valid/ready byte channels
// Input channel carries raw stream bytes, output channel packet bytes
// with packet boundary flags.
// ----------------------------------------------------------------------------
interface tspmt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface tspmt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       first_of_packet;
  logic       last_of_packet;

  modport source (output valid, output out_byte, output first_of_packet,
                  output last_of_packet, input ready);
  modport sink (input valid, input out_byte, input first_of_packet,
                input last_of_packet, output ready);
endinterface

@@ src/tspmt_cfg.sv @@
// ----------------------------------------------------------------------------
// tspmt_cfg - APB configuration registers
// Write on the access phase, read back through prdata.
// ----------------------------------------------------------------------------
module tspmt_cfg
  import tspmt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output cfg_t              cfg
);

  logic       wr;
  logic [2:0] idx;

  assign wr  = psel && penable && pwrite;
  assign idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr) begin
      case (idx)
        REG_PMT_ENABLE:   cfg.pmt_enable   <= pwdata[0];
        REG_PMT_PID:      cfg.pmt_pid      <= pwdata[12:0];
        REG_AC3_ENABLE:   cfg.ac3_enable   <= pwdata[0];
        REG_AC3_PID:      cfg.ac3_pid      <= pwdata[12:0];
        REG_STREAM_LIMIT: cfg.stream_limit <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PMT_ENABLE:   prdata = {31'h0, cfg.pmt_enable};
      REG_PMT_PID:      prdata = {19'h0, cfg.pmt_pid};
      REG_AC3_ENABLE:   prdata = {31'h0, cfg.ac3_enable};
      REG_AC3_PID:      prdata = {19'h0, cfg.ac3_pid};
      REG_STREAM_LIMIT: prdata = {27'h0, cfg.stream_limit};
      default:          prdata = 32'h0;
    endcase
  end

endmodule

@@ src/tspmt_core.sv @@
// ----------------------------------------------------------------------------
// tspmt_core - per-byte packet tracking, PMT rewrite and CRC insertion
// Three-slot delay line, field tracking on entry, rewrite on exit,
// result held in an output register.
// ----------------------------------------------------------------------------
module tspmt_core
  import tspmt_pkg::*;
#(
  parameter int MAX_STREAMS = MAX_STREAMS_DEF
)
(
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  tspmt_in_if.sink    ts_in,
  tspmt_out_if.source ts_out,
  output status_t status
);

  localparam int ESW = $clog2(MAX_STREAMS + 1);
  localparam int CW  = (ESW > 5) ? ESW : 5;

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_SEARCH = 2'd1;
  localparam logic [1:0] PH_DONE   = 2'd2;

  // state
  logic [7:0]     dly [3];
  logic [7:0]     tag [3];
  logic [2:0]     dvalid;
  logic [7:0]     byte_position;
  logic           in_packet;
  logic           is_pmt_packet;
  logic [31:0]    crc_register;
  logic [7:0]     section_length;
  logic [12:0]    next_entry_offset;
  logic [ESW-1:0] entries_seen;
  logic [1:0]     entry_phase;
  logic           ac3_patched;

  logic [7:0]     dly_next [3];
  logic [7:0]     tag_next [3];
  logic [2:0]     dvalid_next;
  logic [7:0]     byte_position_next;
  logic           in_packet_next;
  logic           is_pmt_packet_next;
  logic [31:0]    crc_register_next;
  logic [7:0]     section_length_next;
  logic [12:0]    next_entry_offset_next;
  logic [ESW-1:0] entries_seen_next;
  logic [1:0]     entry_phase_next;
  logic           ac3_patched_next;

  // output register
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_first;
  logic       out_last;

  logic       accept;
  logic       take;
  logic [7:0] b;
  logic [7:0] pos;
  logic [7:0] hi;
  logic [7:0] slot1;
  logic [11:0] len12;
  logic [12:0] pid13;
  logic [7:0] q;
  logic [7:0] v;
  logic [8:0] crc_off;
  logic [8:0] crc_end;
  logic [8:0] qx;
  logic [1:0] crc_idx;

  assign ts_in.ready = !out_valid || ts_out.ready;
  assign accept      = ts_in.valid && ts_in.ready;
  assign b           = ts_in.in_byte;

  assign status.in_packet     = in_packet;
  assign status.byte_position = byte_position;

  always_comb begin
    take                   = 1'b0;
    pos                    = 8'd0;
    hi                     = dly[2];
    slot1                  = dly[1];
    len12                  = {hi[3:0], b};
    pid13                  = {hi[4:0], b};
    byte_position_next     = byte_position;
    in_packet_next         = in_packet;
    is_pmt_packet_next     = is_pmt_packet;
    crc_register_next      = crc_register;
    section_length_next    = section_length;
    next_entry_offset_next = next_entry_offset;
    entries_seen_next      = entries_seen;
    entry_phase_next       = entry_phase;
    ac3_patched_next       = ac3_patched;
    q                      = tag[0];
    v                      = dly[0];
    crc_off                = 9'd0;
    crc_end                = 9'd0;
    qx                     = {1'b0, tag[0]};
    crc_idx                = 2'd0;

    // entry side: hunt for sync, count position, track PMT fields
    if (!in_packet) begin
      if (b == SYNC_BYTE) begin
        in_packet_next         = 1'b1;
        take                   = 1'b1;
        entries_seen_next      = '0;
        entry_phase_next       = PH_IDLE;
        ac3_patched_next       = 1'b0;
        next_entry_offset_next = 13'd0;
      end
    end else begin
      pos  = byte_position + 8'd1;
      take = 1'b1;
    end

    if (take) begin
      byte_position_next = pos;
      if (pos >= PKT_LAST) begin
        in_packet_next = 1'b0;
      end
      if (is_pmt_packet && pos >= 8'd3) begin
        if (pos == 8'd7) begin
          section_length_next = b;
        end
        if (pos == 8'd16) begin
          next_entry_offset_next = 13'd17 + {1'b0, len12};
          entry_phase_next       = PH_SEARCH;
        end else if (entry_phase == PH_SEARCH) begin
          if ({6'd0, pos} == {1'b0, next_entry_offset} + 14'd2) begin
            if (cfg.ac3_enable && ({1'b0, pos} <= {1'b0, section_length_next} + 9'd3)
                && (CW'(entries_seen) < CW'(cfg.stream_limit))
                && (entries_seen < ESW'(MAX_STREAMS))) begin
              entries_seen_next = entries_seen + ESW'(1);
              if (pid13 == cfg.ac3_pid) begin
                slot1            = AC3_TYPE;   // stream type byte sits one slot back
                ac3_patched_next = 1'b1;
                entry_phase_next = PH_DONE;
              end
            end else begin
              entry_phase_next = PH_DONE;
            end
          end else if ({6'd0, pos} == {1'b0, next_entry_offset} + 14'd4) begin
            next_entry_offset_next = next_entry_offset + 13'd5 + {1'b0, len12};
          end
        end
      end
    end

    // exit side: PMT decision on byte 0, rewrites, CRC
    if (dvalid[0]) begin
      if (q == 8'd0) begin
        is_pmt_packet_next = cfg.pmt_enable && ({slot1[4:0], dly[2]} == cfg.pmt_pid);
        crc_register_next  = CRC_INIT;
      end
      if (is_pmt_packet_next) begin
        crc_off = {1'b0, section_length_next} + 9'd4;
        crc_end = crc_off + 9'd3;
        if (qx >= crc_off && qx <= crc_end) begin
          crc_idx = 2'd3 - 2'(qx - crc_off);
          v       = crc_register_next[{crc_idx, 3'b000} +: 8];
        end else begin
          if (q == 8'd8) v = 8'd0;
          if (q == 8'd9) v = 8'd1;
          if (q >= 8'd5 && qx < crc_off) begin
            crc_register_next = crc_feed(crc_register_next, v);
          end
        end
      end
    end

    dly_next[0] = slot1;
    dly_next[1] = dly[2];
    dly_next[2] = take ? b : 8'd0;
    tag_next[0] = tag[1];
    tag_next[1] = tag[2];
    tag_next[2] = take ? pos : 8'd0;
    dvalid_next = {take, dvalid[2:1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        dly[i] <= 8'd0;
        tag[i] <= 8'd0;
      end
      dvalid            <= 3'd0;
      byte_position     <= 8'd0;
      in_packet         <= 1'b0;
      is_pmt_packet     <= 1'b0;
      crc_register      <= CRC_INIT;
      section_length    <= 8'd0;
      next_entry_offset <= 13'd0;
      entries_seen      <= '0;
      entry_phase       <= PH_IDLE;
      ac3_patched       <= 1'b0;
    end else if (accept) begin
      dly               <= dly_next;
      tag               <= tag_next;
      dvalid            <= dvalid_next;
      byte_position     <= byte_position_next;
      in_packet         <= in_packet_next;
      is_pmt_packet     <= is_pmt_packet_next;
      crc_register      <= crc_register_next;
      section_length    <= section_length_next;
      next_entry_offset <= next_entry_offset_next;
      entries_seen      <= entries_seen_next;
      entry_phase       <= entry_phase_next;
      ac3_patched       <= ac3_patched_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= dvalid[0];
    end else if (ts_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && dvalid[0]) begin
      out_byte  <= v;
      out_first <= (q == 8'd0);
      out_last  <= (q == PKT_LAST);
    end
  end

  assign ts_out.valid           = out_valid;
  assign ts_out.out_byte        = out_byte;
  assign ts_out.first_of_packet = out_first;
  assign ts_out.last_of_packet  = out_last;

endmodule

@@ src/ts_pmt_stream_rewriter.sv @@
// ----------------------------------------------------------------------------
// ts_pmt_stream_rewriter - transport stream PMT rewriter with CRC regeneration
// Throughput: one byte per cycle; a byte is taken whenever the result register is free or drains.
// Path: a packet byte moves through the delay line on accepted input beats, then the output register.
// Reset: synchronous, active high; clears config, delay line, packet tracking and output valid.
// ----------------------------------------------------------------------------
//
// Structure:
//   tspmt_cfg  - APB register bank (pmt_enable, pmt_pid, ac3_enable, ac3_pid,
//                stream_limit at byte addresses 0, 4, 8, 12, 16).
//   tspmt_core - one pass per accepted beat: sync hunt and byte counting on
//                the way in, PMT field tracking (section length, ES entry
//                walk, AC3 stream type patch), then on the way out the
//                program number rewrite and CRC-32/MPEG-2 insertion.
//
// The delay line only advances on accepted input beats, so a packet's tail
// is flushed out by whatever bytes follow it. Bytes dropped while hunting
// for sync occupy an empty slot and produce no output beat.
//
module ts_pmt_stream_rewriter
  import tspmt_pkg::*;
#(
  parameter int MAX_STREAMS = MAX_STREAMS_DEF
)
(
  input  logic              clk,
  input  logic              rst,
  tspmt_in_if.sink          ts_in,
  tspmt_out_if.source       ts_out,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t    cfg;
  status_t status;

  assign pready = 1'b1;

  tspmt_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  tspmt_core #(
    .MAX_STREAMS (MAX_STREAMS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .ts_in  (ts_in),
    .ts_out (ts_out),
    .status (status)
  );

`ifndef SYNTHESIS
  // position never parks on the last byte while still inside a packet
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    status.in_packet |-> status.byte_position < PKT_LAST)
    else $error("byte position out of range inside packet");

  // the sync byte is never rewritten and never doubles as the last byte
  a_first_sync: assert property (@(posedge clk) disable iff (rst)
    ts_out.valid && ts_out.first_of_packet |->
      ts_out.out_byte == SYNC_BYTE && !ts_out.last_of_packet)
    else $error("packet start beat is not a plain sync byte");

  // non-sync bytes between packets must not open a packet
  a_hunt: assert property (@(posedge clk) disable iff (rst)
    ts_in.valid && ts_in.ready && !status.in_packet && ts_in.in_byte != SYNC_BYTE
      |=> !status.in_packet)
    else $error("packet opened without sync byte");

  // packets close after exactly 188 bytes
  a_close: assert property (@(posedge clk) disable iff (rst)
    ts_in.valid && ts_in.ready && status.in_packet
      && status.byte_position == PKT_LAST - 8'd1 |=> !status.in_packet)
    else $error("packet did not close at byte 187");
`endif

endmodule
